FILE: hdl/pta_pkg.sv
package pta_pkg;

  localparam int unsigned THREADS_DEF    = 4;
  localparam int unsigned LIST_DEPTH_DEF = 16;
  localparam int unsigned SEED_NODES_DEF = 3;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_INIT  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_SEED_FAIL = 2'd3;

  localparam logic [1:0] REG_NODE_BYTES = 2'd0;
  localparam logic [1:0] REG_AREA_START = 2'd1;
  localparam logic [1:0] REG_AREA_END   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  thread_id;
    logic [1:0]  owner_thread;
    logic [31:0] node_offset;
  } req_t;

  typedef struct packed {
    logic [31:0] result_offset;
    logic [1:0]  status;
  } rsp_t;

endpackage

FILE: hdl/pta_entry_mem.sv
module pta_entry_mem #(
  parameter int unsigned AW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);
  logic [31:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: hdl/per_thread_node_allocator.sv
// Node allocator with a FIFO free list per (freeing thread, owner thread) pair and a bump
// pointer. Commands are taken when start is high and busy is low; each command yields one
// result, shown for one cycle with done_o, which cannot be stalled. An allocate examines up
// to THREADS lists, and initialize seeds SEED_NODES nodes into each thread's own list; the
// timing of free, allocate and initialize is set by the single write port of the entry
// memory, its registered read ahead of a pop and the list-by-list scan. List pointers and
// counts sit in flops cleared by reset and init.
module per_thread_node_allocator
  import pta_pkg::*;
#(
  parameter int unsigned THREADS    = THREADS_DEF,
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF,
  parameter int unsigned SEED_NODES = SEED_NODES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  pta_pkg::req_t      req_i,
  output logic               done_o,
  output pta_pkg::rsp_t      rsp_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  localparam int unsigned NL  = THREADS * THREADS;
  localparam int unsigned TW  = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int unsigned LW  = (NL > 1) ? $clog2(NL) : 1;
  localparam int unsigned DW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AW  = LW + DW;
  localparam int unsigned SW  = $clog2(SEED_NODES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_READ, S_POP, S_BUMP, S_SEED, S_DONE
  } state_e;

  state_e      state_q;
  logic [15:0] node_bytes_q;
  logic [31:0] area_start_q, area_end_q, area_next_q;
  logic [DW-1:0] rd_idx_q [NL];
  logic [CW-1:0] cnt_q    [NL];
  logic [TW-1:0] tid_q, scan_q;
  logic [LW-1:0] lst_q;
  logic [SW-1:0] seed_k_q;
  logic [1:0]    kind_q;
  rsp_t          rsp_q;
  logic          done_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  logic [32:0] bump_end;
  logic        bump_ok;
  assign bump_end = {1'b0, area_next_q} + {17'd0, node_bytes_q};
  assign bump_ok  = bump_end <= {1'b0, area_end_q};

  // thread reduction modulo THREADS
  function automatic logic [TW-1:0] red(input logic [1:0] t);
    return TW'(32'(t) % THREADS);
  endfunction

  logic [TW-1:0] rtid, rown;
  logic [LW-1:0] free_l, scan_l;
  assign rtid   = red(req_i.thread_id);
  assign rown   = red(req_i.owner_thread);
  assign free_l = LW'(32'(rtid) * THREADS + 32'(rown));
  assign scan_l = LW'(32'(scan_q) * THREADS + 32'(tid_q));

  logic [DW-1:0] wpos_free, wpos_seed;
  assign wpos_free = DW'((32'(rd_idx_q[free_l]) + 32'(cnt_q[free_l])) % LIST_DEPTH);
  assign wpos_seed = DW'(32'(cnt_q[lst_q]) % LIST_DEPTH);

  logic accept;
  assign accept      = start && !busy;
  assign busy        = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    we    = 1'b0;
    waddr = {lst_q, wpos_seed};
    wdata = area_next_q;
    raddr = {lst_q, rd_idx_q[lst_q]};
    if (accept && req_i.kind == KIND_FREE) begin
      we    = cnt_q[free_l] < CW'(LIST_DEPTH);
      waddr = {free_l, wpos_free};
      wdata = req_i.node_offset;
    end else if (state_q == S_SEED) begin
      we = (seed_k_q < SW'(SEED_NODES)) && (cnt_q[lst_q] < CW'(LIST_DEPTH)) && bump_ok;
    end
  end

  pta_entry_mem #(.AW(AW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_bytes_q <= 16'd64;
      area_start_q <= '0;
      area_end_q   <= '0;
      area_next_q  <= '0;
      for (int i = 0; i < NL; i++) begin
        rd_idx_q[i] <= '0;
        cnt_q[i]    <= '0;
      end
      tid_q    <= '0;
      scan_q   <= '0;
      lst_q    <= '0;
      seed_k_q <= '0;
      kind_q   <= '0;
      rsp_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_NODE_BYTES: node_bytes_q <= cfg_data_i[15:0];
          REG_AREA_START: area_start_q <= cfg_data_i;
          REG_AREA_END:   area_end_q   <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            kind_q <= req_i.kind;
            tid_q  <= rtid;
            rsp_q  <= {32'd0, (req_i.kind == KIND_FREE && !we) ? ST_FULL : ST_OK};
            case (req_i.kind)
              KIND_ALLOC: begin
                lst_q <= LW'(32'(rtid) * THREADS + 32'(rtid));
                if (cnt_q[LW'(32'(rtid) * THREADS + 32'(rtid))] >= CW'(2)) begin
                  state_q <= S_READ;
                end else begin
                  scan_q  <= '0;
                  state_q <= S_SCAN;
                end
              end
              KIND_FREE: begin
                if (we) cnt_q[free_l] <= cnt_q[free_l] + 1'b1;
                state_q <= S_DONE;
              end
              KIND_INIT: begin
                for (int i = 0; i < NL; i++) begin
                  rd_idx_q[i] <= '0;
                  cnt_q[i]    <= '0;
                end
                area_next_q <= area_start_q;
                scan_q      <= '0;
                seed_k_q    <= '0;
                lst_q       <= '0;
                state_q     <= S_SEED;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          if (cnt_q[scan_l] >= CW'(2)) begin
            lst_q   <= scan_l;
            state_q <= S_READ;
          end else if (32'(scan_q) == THREADS - 1) begin
            state_q <= S_BUMP;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        S_READ: begin
          // head entry of lst_q is addressed this cycle
          state_q <= S_POP;
        end
        S_POP: begin
          // raddr was presented last cycle; commit the pop now
          rsp_q.result_offset <= rdata;
          rd_idx_q[lst_q] <= DW'((32'(rd_idx_q[lst_q]) + 1) % LIST_DEPTH);
          cnt_q[lst_q]    <= cnt_q[lst_q] - 1'b1;
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_BUMP: begin
          if (bump_ok) begin
            rsp_q.result_offset <= area_next_q;
            area_next_q <= bump_end[31:0];
          end else begin
            rsp_q.status <= ST_EXHAUSTED;
          end
          state_q <= S_DONE;
        end
        S_SEED: begin
          if (seed_k_q == SW'(SEED_NODES)) begin
            if (32'(scan_q) == THREADS - 1) begin
              state_q <= S_DONE;
            end else begin
              scan_q   <= scan_q + 1'b1;
              lst_q    <= LW'((32'(scan_q) + 1) * THREADS + 32'(scan_q) + 1);
              seed_k_q <= '0;
            end
          end else if (we) begin
            cnt_q[lst_q] <= cnt_q[lst_q] + 1'b1;
            area_next_q  <= bump_end[31:0];
            seed_k_q     <= seed_k_q + 1'b1;
          end else begin
            rsp_q.status <= ST_SEED_FAIL;
            state_q      <= S_DONE;
          end
        end
        S_DONE: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  always_comb begin
    rsp_o = rsp_q;
    if (state_q == S_IDLE && done_q && kind_q != KIND_ALLOC) rsp_o.result_offset = '0;
  end
endmodule
